// ----- design/cnq_pkg.sv -----
// Shared widths, codes and record types for the camera neighbor query unit.
package cnq_pkg;

  // Field widths of the request and response items
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned POS_W      = 20;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned INL_W      = 16;
  localparam int unsigned LIM_W      = 7;
  localparam int unsigned RAD_W      = 19;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;

  // Radius check arithmetic
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned SQ_W       = 2 * RAD_W;
  localparam int unsigned SUM_W      = SQ_W + 2;

  // Response queue: one slot per scan stage that may still push, plus the final push
  localparam int unsigned RSP_DEPTH   = 16;
  localparam int unsigned RSP_PTR_W   = $clog2(RSP_DEPTH);
  localparam int unsigned RSP_CNT_W   = $clog2(RSP_DEPTH + 1);
  localparam int unsigned SCAN_SLOTS  = 6;
  localparam int unsigned ISSUE_LIMIT = RSP_DEPTH - SCAN_SLOTS - 1;

  // Register reset values
  localparam logic             EDGE_MODE_RST  = 1'b0;
  localparam logic [RAD_W-1:0] RADIUS_RST     = 19'd5632;
  localparam logic [INL_W-1:0] INLIER_THR_RST = 16'd50;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_VIEW  = 2'd1,
    REQ_EDGE  = 2'd2,
    REQ_QUERY = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_MODE        = 2'd0,
    CFG_SEARCH_RADIUS    = 2'd1,
    CFG_INLIER_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [INL_W-1:0] inliers;
  } edge_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbor_index;
    pos_t             pos;
    logic             found;
    logic             last;
  } rsp_t;

  // Search settings handed to the radius pipeline
  typedef struct packed {
    logic             edge_mode;
    logic [RAD_W-1:0] radius;
    logic [SQ_W-1:0]  radius_sq;
  } srch_cfg_t;

endpackage

// ----- design/cnq_if.sv -----
// Request and response channel interfaces of the camera neighbor query unit.
interface cnq_req_if import cnq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [POS_W-1:0] view_x;
  logic signed [POS_W-1:0] view_y;
  logic signed [POS_W-1:0] view_z;
  logic [IDX_W-1:0]        edge_first;
  logic [IDX_W-1:0]        edge_second;
  logic [INL_W-1:0]        edge_inliers;
  logic [IDX_W-1:0]        query_node;
  logic [LIM_W-1:0]        result_limit;

  modport source (
    output valid, req_type, view_x, view_y, view_z, edge_first, edge_second,
           edge_inliers, query_node, result_limit,
    input  ready
  );
  modport sink (
    input  valid, req_type, view_x, view_y, view_z, edge_first, edge_second,
           edge_inliers, query_node, result_limit,
    output ready
  );
endinterface

interface cnq_rsp_if import cnq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        neighbor_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    found;
  logic                    last;

  modport source (
    output valid, neighbor_index, pos_x, pos_y, pos_z, found, last,
    input  ready
  );
  modport sink (
    input  valid, neighbor_index, pos_x, pos_y, pos_z, found, last,
    output ready
  );
endinterface

// ----- design/cnq_view_store.sv -----
// View position table: append-only memory with a fill count and one registered read port.
module cnq_view_store import cnq_pkg::*; #(
  parameter int unsigned MAX_VIEWS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               clear_i,
  input  logic                               wr_en_i,
  input  pos_t                               wr_pos_i,
  input  logic                               rd_en_i,
  input  logic [$clog2(MAX_VIEWS)-1:0]       rd_addr_i,
  output pos_t                               rd_pos_o,
  output logic [$clog2(MAX_VIEWS + 1)-1:0]   count_o
);

  localparam int unsigned VAW = $clog2(MAX_VIEWS);
  localparam int unsigned VCW = $clog2(MAX_VIEWS + 1);

  pos_t           mem [MAX_VIEWS];
  pos_t           rd_q;
  logic [VCW-1:0] count_q;
  logic           room;
  logic           wr_take;

  assign room    = (count_q != VCW'(MAX_VIEWS));
  assign wr_take = wr_en_i && !clear_i && room;

  // Advance the fill count; drop appends once full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
    end else if (wr_take) begin
      count_q <= count_q + VCW'(1);
    end
  end

  // Write at the fill count; the read data is registered
  always_ff @(posedge clk_i) begin
    if (wr_take) begin
      mem[count_q[VAW-1:0]] <= wr_pos_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_pos_o = rd_q;
  assign count_o  = count_q;

endmodule

// ----- design/cnq_edge_store.sv -----
// Covisibility edge table: append-only memory with a fill count and one registered read port.
module cnq_edge_store import cnq_pkg::*; #(
  parameter int unsigned MAX_EDGES = 1024
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   clear_i,
  input  logic                                                   wr_en_i,
  input  edge_t                                                  wr_edge_i,
  input  logic                                                   rd_en_i,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0]   rd_addr_i,
  output edge_t                                                  rd_edge_o,
  output logic [$clog2(MAX_EDGES + 1)-1:0]                       count_o
);

  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);

  edge_t          mem [MAX_EDGES];
  edge_t          rd_q;
  logic [ECW-1:0] count_q;
  logic           room;
  logic           wr_take;

  assign room    = (count_q != ECW'(MAX_EDGES));
  assign wr_take = wr_en_i && !clear_i && room;

  // Advance the fill count; drop appends once full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
    end else if (wr_take) begin
      count_q <= count_q + ECW'(1);
    end
  end

  // Write at the fill count; the read data is registered
  always_ff @(posedge clk_i) begin
    if (wr_take) begin
      mem[count_q[EAW-1:0]] <= wr_edge_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_edge_o = rd_q;
  assign count_o   = count_q;

endmodule

// ----- design/cnq_dist_pipe.sv -----
// Three-stage radius check: absolute differences, squares, then sum and compare.
module cnq_dist_pipe import cnq_pkg::*; #(
  parameter int unsigned VAW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srch_cfg_t      cfg_i,
  input  pos_t           ref_i,
  input  logic           in_vld_i,
  input  logic [VAW-1:0] in_idx_i,
  input  pos_t           in_pos_i,
  output logic           hit_o,
  output logic [VAW-1:0] hit_idx_o,
  output pos_t           hit_pos_o,
  output logic           busy_o
);

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                 input logic signed [POS_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic [DIFF_W-1:0] ad_x, ad_y, ad_z, rad_ext;
  logic              far_d;

  logic              v3_q, v4_q, v5_q;
  logic              far3_q, far4_q, far5_q;
  logic [RAD_W-1:0]  d3x_q, d3y_q, d3z_q;
  logic [SQ_W-1:0]   sq4x_q, sq4y_q, sq4z_q;
  logic [SUM_W-1:0]  sum5_q;
  logic [VAW-1:0]    idx3_q, idx4_q, idx5_q;
  pos_t              pos3_q, pos4_q, pos5_q;

  // Per-axis distance and early reject against the radius
  assign ad_x    = abs_diff(in_pos_i.x, ref_i.x);
  assign ad_y    = abs_diff(in_pos_i.y, ref_i.y);
  assign ad_z    = abs_diff(in_pos_i.z, ref_i.z);
  assign rad_ext = DIFF_W'(cfg_i.radius);
  assign far_d   = (ad_x > rad_ext) || (ad_y > rad_ext) || (ad_z > rad_ext);

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= in_vld_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage data: differences, squares, sum
  always_ff @(posedge clk_i) begin
    far3_q <= far_d;
    d3x_q  <= ad_x[RAD_W-1:0];
    d3y_q  <= ad_y[RAD_W-1:0];
    d3z_q  <= ad_z[RAD_W-1:0];
    idx3_q <= in_idx_i;
    pos3_q <= in_pos_i;

    far4_q <= far3_q;
    sq4x_q <= SQ_W'(d3x_q) * SQ_W'(d3x_q);
    sq4y_q <= SQ_W'(d3y_q) * SQ_W'(d3y_q);
    sq4z_q <= SQ_W'(d3z_q) * SQ_W'(d3z_q);
    idx4_q <= idx3_q;
    pos4_q <= pos3_q;

    far5_q <= far4_q;
    sum5_q <= SUM_W'(sq4x_q) + SUM_W'(sq4y_q) + SUM_W'(sq4z_q);
    idx5_q <= idx4_q;
    pos5_q <= pos4_q;
  end

  // Edge hits pass straight through; distance hits need the squared compare
  assign hit_o     = v5_q && (cfg_i.edge_mode ||
                              (!far5_q && (sum5_q <= SUM_W'(cfg_i.radius_sq))));
  assign hit_idx_o = idx5_q;
  assign hit_pos_o = pos5_q;
  assign busy_o    = v3_q || v4_q || v5_q;

endmodule

// ----- design/cnq_rsp_fifo.sv -----
// Response queue that decouples the table scan from the result channel.
module cnq_rsp_fifo import cnq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rsp_t                 push_data_i,
  output logic [RSP_CNT_W-1:0] count_o,
  cnq_rsp_if.source            rsp_o
);

  rsp_t                 mem [RSP_DEPTH];
  logic [RSP_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RSP_CNT_W-1:0] cnt_q;
  logic                 pop;
  rsp_t                 head;

  assign pop  = rsp_o.valid && rsp_o.ready;
  assign head = mem[rd_ptr_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + RSP_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RSP_PTR_W'(1);
      end
      unique case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + RSP_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - RSP_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Store each pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  assign count_o              = cnt_q;
  assign rsp_o.valid          = (cnt_q != '0);
  assign rsp_o.neighbor_index = head.neighbor_index;
  assign rsp_o.pos_x          = head.pos.x;
  assign rsp_o.pos_y          = head.pos.y;
  assign rsp_o.pos_z          = head.pos.z;
  assign rsp_o.found          = head.found;
  assign rsp_o.last           = head.last;

endmodule

// ----- design/camera_neighbor_query_unit.sv -----
// Camera neighbor query unit: view and edge tables with a scanning neighbor search.
//
// The unit keeps a table of view positions and a table of covisibility edges, each in its
// own synchronous memory with one write port and one registered read port, filled by
// append items; a clear item empties both by resetting their fill counts, so no clearing
// pass runs after reset. Clear and append items leave the unit idle. A query scans one
// table entry per cycle through that table's read port while the response queue has
// room; in distance mode one extra read fetches the queried view first, and the scan
// stops early once result_limit hits (at most MAX_NEIGHBORS) have been found. Each
// candidate view is read back from the view memory and passes a three-stage pipeline,
// which in distance mode applies the square-and-compare test, before a hit enters a
// 16-entry response queue; when the result channel stalls the scan pauses so the queue
// never overflows. The last result of every query carries last = 1; a query for an
// unknown view, or one that finds nothing, returns a single item with found = 0.
module camera_neighbor_query_unit import cnq_pkg::*; #(
  parameter int unsigned MAX_VIEWS     = 256,
  parameter int unsigned MAX_EDGES     = 1024,
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cnq_req_if.sink               req_i,
  cnq_rsp_if.source             rsp_o
);

  localparam int unsigned VAW = $clog2(MAX_VIEWS);
  localparam int unsigned VCW = $clog2(MAX_VIEWS + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned SW  = (VCW > ECW) ? VCW : ECW;
  localparam int unsigned CW  = (VCW > IDX_W) ? VCW : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REF,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Configuration registers
  logic             edge_mode_q;
  logic [RAD_W-1:0] radius_q;
  logic [INL_W-1:0] inlier_thr_q;
  logic [SQ_W-1:0]  radius_sq_q;
  srch_cfg_t        srch_cfg;

  // Sequencer state
  state_e           state_q;
  logic [IDX_W-1:0] node_q;
  logic [LIM_W-1:0] lim_q;
  logic [LIM_W-1:0] hit_cnt_q;
  logic [SW-1:0]    ctr_q;
  logic             s1_q, s2_q;
  logic             pend_vld_q;
  logic [VAW-1:0]   s1_idx_q, s2_idx_q;
  pos_t             ref_q;
  rsp_t             pend_q;

  // Request decode
  req_type_e        req_kind;
  logic             accept;
  logic             clr, view_wr, edge_wr;
  logic             node_ok;
  logic [LIM_W-1:0] lim_sat;

  // Table ports
  pos_t             wr_pos;
  edge_t            wr_edge;
  pos_t             view_rd;
  edge_t            edge_rd;
  logic [VCW-1:0]   view_cnt;
  logic [ECW-1:0]   edge_cnt;
  logic             vrd_en;
  logic [VAW-1:0]   vrd_addr;
  logic             erd_en;

  // Scan control
  logic [SW-1:0]    scan_len;
  logic             more;
  logic             issue;
  logic [IDX_W-1:0] other;
  logic             edge_hit;
  logic             keep;
  logic             s1_fwd;
  logic             pipe_hit;
  logic [VAW-1:0]   pipe_idx;
  pos_t             pipe_pos;
  logic             pipe_busy;
  logic             pipe_empty;
  logic             scan_done;
  logic             hit_take;

  // Response queue
  logic [RSP_CNT_W-1:0] fifo_cnt;
  logic                 fifo_full;
  logic                 fifo_push;
  logic                 finish_push;
  rsp_t                 push_data;
  rsp_t                 hit_rsp;
  rsp_t                 miss_rsp;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_mode_q  <= EDGE_MODE_RST;
      radius_q     <= RADIUS_RST;
      inlier_thr_q <= INLIER_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_EDGE_MODE:        edge_mode_q  <= cfg_data_i[0];
        CFG_SEARCH_RADIUS:    radius_q     <= cfg_data_i[RAD_W-1:0];
        CFG_INLIER_THRESHOLD: inlier_thr_q <= cfg_data_i[INL_W-1:0];
        default: ;
      endcase
    end
  end

  // Square the radius once for the distance compare
  always_ff @(posedge clk_i) begin
    radius_sq_q <= SQ_W'(radius_q) * SQ_W'(radius_q);
  end

  assign srch_cfg = '{edge_mode: edge_mode_q, radius: radius_q, radius_sq: radius_sq_q};

  // Decode the incoming item
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_kind    = req_type_e'(req_i.req_type);
  assign clr         = accept && (req_kind == REQ_CLEAR);
  assign view_wr     = accept && (req_kind == REQ_VIEW);
  assign edge_wr     = accept && (req_kind == REQ_EDGE);
  assign node_ok     = (CW'(req_i.query_node) < CW'(view_cnt));
  assign lim_sat     = (req_i.result_limit > LIM_W'(MAX_NEIGHBORS)) ?
                       LIM_W'(MAX_NEIGHBORS) : req_i.result_limit;

  assign wr_pos  = '{x: req_i.view_x, y: req_i.view_y, z: req_i.view_z};
  assign wr_edge = '{first: req_i.edge_first, second: req_i.edge_second,
                     inliers: req_i.edge_inliers};

  // Issue one table read per cycle while the queue has room
  assign scan_len = edge_mode_q ? SW'(edge_cnt) : SW'(view_cnt);
  assign more     = (ctr_q < scan_len) && (hit_cnt_q < lim_q);
  assign issue    = (state_q == ST_SCAN) && more && (fifo_cnt < RSP_CNT_W'(ISSUE_LIMIT));
  assign erd_en   = issue && edge_mode_q;

  // Filter the edge that came back from the first read, or the scanned view index
  assign other    = (edge_rd.first == node_q) ? edge_rd.second : edge_rd.first;
  assign edge_hit = (edge_rd.inliers >= inlier_thr_q) &&
                    ((edge_rd.first == node_q) || (edge_rd.second == node_q)) &&
                    (CW'(other) < CW'(view_cnt));
  assign keep     = (CW'(s1_idx_q) != CW'(node_q));
  assign s1_fwd   = s1_q && (edge_mode_q ? edge_hit : keep);

  // Share the view read port between the reference fetch and the scan
  assign vrd_en   = (state_q == ST_LOAD) || s1_fwd;
  assign vrd_addr = (state_q == ST_LOAD) ? VAW'(node_q) :
                    (edge_mode_q ? VAW'(other) : s1_idx_q);

  assign pipe_empty = !s1_q && !s2_q && !pipe_busy;
  assign scan_done  = (state_q == ST_SCAN) && !more && pipe_empty;
  assign hit_take   = pipe_hit && (hit_cnt_q < lim_q);

  // Push the previous hit on a new one; push the tail item on finish
  assign fifo_full   = (fifo_cnt == RSP_CNT_W'(RSP_DEPTH));
  assign finish_push = (state_q == ST_FINISH) && !fifo_full;
  assign fifo_push   = finish_push || (hit_take && pend_vld_q);
  assign hit_rsp     = '{neighbor_index: IDX_W'(pipe_idx), pos: pipe_pos,
                         found: 1'b1, last: 1'b0};
  assign miss_rsp    = '{neighbor_index: '0, pos: '0, found: 1'b0, last: 1'b1};

  always_comb begin
    push_data = pend_q;
    if (state_q == ST_FINISH) begin
      if (pend_vld_q) begin
        push_data.last = 1'b1;
      end else begin
        push_data = miss_rsp;
      end
    end
  end

  // Sequence queries and track scan progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      node_q     <= '0;
      lim_q      <= '0;
      hit_cnt_q  <= '0;
      ctr_q      <= '0;
      s1_q       <= 1'b0;
      s2_q       <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      s1_q <= issue;
      s2_q <= s1_fwd;
      if (issue) begin
        ctr_q <= ctr_q + SW'(1);
      end
      if (hit_take) begin
        hit_cnt_q <= hit_cnt_q + LIM_W'(1);
      end
      priority if (finish_push) begin
        pend_vld_q <= 1'b0;
      end else if (hit_take) begin
        pend_vld_q <= 1'b1;
      end else begin
        pend_vld_q <= pend_vld_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept && (req_kind == REQ_QUERY)) begin
            node_q    <= req_i.query_node;
            lim_q     <= lim_sat;
            hit_cnt_q <= '0;
            ctr_q     <= '0;
            priority if (!node_ok) begin
              state_q <= ST_FINISH;
            end else if (edge_mode_q) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_LOAD;
            end
          end
        end
        ST_LOAD:   state_q <= ST_REF;
        ST_REF:    state_q <= ST_SCAN;
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!fifo_full) begin
            state_q <= ST_IDLE;
          end
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  // Carry indices, reference position and pending hit
  always_ff @(posedge clk_i) begin
    s1_idx_q <= ctr_q[VAW-1:0];
    s2_idx_q <= vrd_addr;
    if (state_q == ST_REF) begin
      ref_q <= view_rd;
    end
    if (hit_take) begin
      pend_q <= hit_rsp;
    end
  end

  cnq_view_store #(
    .MAX_VIEWS (MAX_VIEWS)
  ) u_view_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clr),
    .wr_en_i   (view_wr),
    .wr_pos_i  (wr_pos),
    .rd_en_i   (vrd_en),
    .rd_addr_i (vrd_addr),
    .rd_pos_o  (view_rd),
    .count_o   (view_cnt)
  );

  cnq_edge_store #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edge_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clr),
    .wr_en_i   (edge_wr),
    .wr_edge_i (wr_edge),
    .rd_en_i   (erd_en),
    .rd_addr_i (ctr_q[EAW-1:0]),
    .rd_edge_o (edge_rd),
    .count_o   (edge_cnt)
  );

  cnq_dist_pipe #(
    .VAW (VAW)
  ) u_dist_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (srch_cfg),
    .ref_i     (ref_q),
    .in_vld_i  (s2_q),
    .in_idx_i  (s2_idx_q),
    .in_pos_i  (view_rd),
    .hit_o     (pipe_hit),
    .hit_idx_o (pipe_idx),
    .hit_pos_o (pipe_pos),
    .busy_o    (pipe_busy)
  );

  cnq_rsp_fifo u_rsp_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (push_data),
    .count_o     (fifo_cnt),
    .rsp_o       (rsp_o)
  );

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (fifo_cnt != RSP_CNT_W'(RSP_DEPTH)))
    else $error("response queue pushed while full");

  a_hits_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (hit_cnt_q <= lim_q))
    else $error("hit count exceeded the query limit");

  a_finish_empties_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish_push |=> (!pend_vld_q && (state_q == ST_IDLE)))
    else $error("pending hit survived the end of a query");

  a_pending_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (hit_cnt_q != '0))
    else $error("pending hit without a counted hit");
`endif

endmodule
